// File: design/b64sc_pkg.sv
// Package for the Base64 stream codec: request, response and job types,
// the pad mark, register slot constants and the alphabet conversion functions.
// Used by every module of the codec; depends on nothing.
package b64sc_pkg;

   localparam logic [7:0] PAD_MARK       = 8'h3D;
   localparam int         CSR_ADDR_W     = 3;
   localparam logic       CSR_MODE_SLOT  = 1'b0;
   localparam int         JOB_CHARS      = 4;
   localparam int         JOB_NUM_W      = 3;

   localparam logic       MODE_ENCODE    = 1'b0;
   localparam logic       MODE_DECODE    = 1'b1;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       run_last;
      logic       message_end;
   } rsp_type;

   typedef struct packed {
      logic [JOB_CHARS-1:0][7:0] chars;
      logic [JOB_NUM_W-1:0]      num;
      logic                      has_data;
      logic                      last;
   } job_type;

   function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
      logic [7:0] w;
      logic [7:0] c;
      w = {2'b00, v};
      if (v < 6'd26) begin
         c = 8'h41 + w;
      end else if (v < 6'd52) begin
         c = 8'h61 + w - 8'd26;
      end else if (v < 6'd62) begin
         c = 8'h30 + w - 8'd52;
      end else if (v == 6'd62) begin
         c = 8'h2B;
      end else begin
         c = 8'h2F;
      end
      return c;
   endfunction

   // Bit 6 of the result is set when the character belongs to the alphabet.
   function automatic logic [6:0] char_to_sextet(input logic [7:0] c);
      logic [7:0] d;
      logic       hit;
      d   = 8'd0;
      hit = 1'b1;
      if (c >= 8'h41 && c <= 8'h5A) begin
         d = c - 8'h41;
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         d = c - 8'h61 + 8'd26;
      end else if (c >= 8'h30 && c <= 8'h39) begin
         d = c - 8'h30 + 8'd52;
      end else if (c == 8'h2B) begin
         d = 8'd62;
      end else if (c == 8'h2F) begin
         d = 8'd63;
      end else begin
         hit = 1'b0;
      end
      return {hit, d[5:0]};
   endfunction

endpackage

// File: design/base64_stream_codec.sv
// Streaming Base64 encoder and decoder, selected by the codec_mode register.
// The first response of a request passes through the job queue and then the response
// register. Throughput: one request per cycle while the job queue is not full and each
// yields at most one response; the response register emits one character per cycle while
// it is popped, and a request with several responses holds it until its last is popped.
// Reset clears the mode to encode, the group state and the job queue.
module base64_stream_codec #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  b64sc_pkg::req_type                  req_data,
   output logic                                empty,
   input  logic                                pop,
   output b64sc_pkg::rsp_type                  rsp_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [b64sc_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);

   logic               mode_ff, mode_in;
   logic               mode_wr;
   logic               accept;
   b64sc_pkg::job_type job;
   logic               job_push;
   b64sc_pkg::job_type head;
   logic               q_empty;
   logic               q_full;
   logic               q_rd;

   assign pready  = 1'b1;
   assign mode_wr = psel && penable && pwrite && (paddr[2] == b64sc_pkg::CSR_MODE_SLOT);
   assign mode_in = mode_wr ? pwdata[0] : mode_ff;
   assign prdata  = (paddr[2] == b64sc_pkg::CSR_MODE_SLOT) ? {31'd0, mode_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= b64sc_pkg::MODE_ENCODE;
      end else begin
         mode_ff <= mode_in;
      end
   end

   assign full   = q_full;
   assign accept = push && !q_full;

   b64sc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .mode     (mode_ff),
      .clear    (mode_wr),
      .accept   (accept),
      .req      (req_data),
      .job      (job),
      .job_push (job_push)
   );

   b64sc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr      (job_push),
      .wr_data (job),
      .rd      (q_rd),
      .head    (head),
      .q_empty (q_empty),
      .q_full  (q_full)
   );

   b64sc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_empty  (q_empty),
      .rd       (q_rd),
      .pop      (pop),
      .empty    (empty),
      .rsp_data (rsp_data)
   );

endmodule

// File: design/b64sc_front.sv
// Front end of the Base64 stream codec: accepts requests, keeps the group
// state and turns each request into a job of up to four response characters, or into
// no job when it yields no response. Depends on b64sc_pkg.
module b64sc_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                mode,
   input  logic                clear,
   input  logic                accept,
   input  b64sc_pkg::req_type  req,
   output b64sc_pkg::job_type  job,
   output logic                job_push
);

   logic [1:0] phase_ff, phase_in;
   logic [5:0] held_ff, held_in;
   logic       pad_ff, pad_in;

   logic [7:0] b;
   logic [6:0] dec;
   logic [2:0] n;

   assign b   = req.in_byte;
   assign dec = b64sc_pkg::char_to_sextet(b);

   always_comb begin
      job      = '0;
      n        = 3'd0;
      phase_in = phase_ff;
      held_in  = held_ff;
      pad_in   = pad_ff;
      if (mode == b64sc_pkg::MODE_ENCODE) begin
         case (phase_ff)
            2'd0: begin
               job.chars[0] = b64sc_pkg::sextet_to_char(b[7:2]);
               held_in      = {4'b0000, b[1:0]};
               phase_in     = 2'd1;
               n            = 3'd1;
               if (req.in_last) begin
                  job.chars[1] = b64sc_pkg::sextet_to_char({b[1:0], 4'b0000});
                  job.chars[2] = b64sc_pkg::PAD_MARK;
                  job.chars[3] = b64sc_pkg::PAD_MARK;
                  n            = 3'd4;
               end
            end
            2'd1: begin
               job.chars[0] = b64sc_pkg::sextet_to_char({held_ff[1:0], b[7:4]});
               held_in      = {2'b00, b[3:0]};
               phase_in     = 2'd2;
               n            = 3'd1;
               if (req.in_last) begin
                  job.chars[1] = b64sc_pkg::sextet_to_char({b[3:0], 2'b00});
                  job.chars[2] = b64sc_pkg::PAD_MARK;
                  n            = 3'd3;
               end
            end
            default: begin
               job.chars[0] = b64sc_pkg::sextet_to_char({held_ff[3:0], b[7:6]});
               job.chars[1] = b64sc_pkg::sextet_to_char(b[5:0]);
               held_in      = 6'd0;
               phase_in     = 2'd0;
               n            = 3'd2;
            end
         endcase
      end else if (!pad_ff) begin
         if (b == b64sc_pkg::PAD_MARK) begin
            pad_in   = 1'b1;
            phase_in = 2'd0;
            held_in  = 6'd0;
         end else if (dec[6]) begin
            case (phase_ff)
               2'd0: begin
                  held_in  = dec[5:0];
                  phase_in = 2'd1;
               end
               2'd1: begin
                  job.chars[0] = {held_ff, dec[5:4]};
                  held_in      = {2'b00, dec[3:0]};
                  phase_in     = 2'd2;
                  n            = 3'd1;
               end
               2'd2: begin
                  job.chars[0] = {held_ff[3:0], dec[5:2]};
                  held_in      = {4'b0000, dec[1:0]};
                  phase_in     = 2'd3;
                  n            = 3'd1;
               end
               default: begin
                  job.chars[0] = {held_ff[1:0], dec[5:0]};
                  held_in      = 6'd0;
                  phase_in     = 2'd0;
                  n            = 3'd1;
               end
            endcase
         end
      end
      job.has_data = (n != 3'd0);
      job.last     = req.in_last;
      job.num      = (req.in_last && n == 3'd0) ? 3'd1 : n;
      if (req.in_last) begin
         phase_in = 2'd0;
         held_in  = 6'd0;
         pad_in   = 1'b0;
      end
   end

   assign job_push = accept && (job.num != 3'd0);

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         phase_ff <= 2'd0;
         held_ff  <= 6'd0;
         pad_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
         pad_ff   <= pad_in;
      end
   end

`ifndef SYNTH
   a_encode_phase: assert property (@(posedge clock) disable iff (reset)
      (mode == b64sc_pkg::MODE_ENCODE && !clear && !$past(clear)
       && $past(mode) == b64sc_pkg::MODE_ENCODE) |-> (phase_ff != 2'd3))
      else $error("Encoder group phase reached an impossible value.");
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req.in_last) |=> (phase_ff == 2'd0 && held_ff == 6'd0 && !pad_ff))
      else $error("Group state not cleared after the last request of a message.");
`endif

endmodule

// File: design/b64sc_queue.sv
// Short job queue between the front end and the back end of the codec.
// Holds jobs in registers and presents the oldest one combinationally.
// Depends on b64sc_pkg.
module b64sc_queue #(
   parameter int DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr,
   input  b64sc_pkg::job_type wr_data,
   input  logic               rd,
   output b64sc_pkg::job_type head,
   output logic               q_empty,
   output logic               q_full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   b64sc_pkg::job_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign q_empty = (count_ff == CNT_W'(0));
   assign q_full  = (count_ff == CNT_W'(DEPTH));
   assign head    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : wr_ptr_ff + PTR_W'(1);
      end
      if (rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : rd_ptr_ff + PTR_W'(1);
      end
      if (wr && !rd) begin
         count_in = count_ff + CNT_W'(1);
      end else if (rd && !wr) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// File: design/b64sc_back.sv
// Back end of the codec: walks the characters of the oldest job and loads them
// one per cycle into the response register while it is empty or popped. Depends on b64sc_pkg.
module b64sc_back (
   input  logic               clock,
   input  logic               reset,
   input  b64sc_pkg::job_type head,
   input  logic               q_empty,
   output logic               rd,
   input  logic               pop,
   output logic               empty,
   output b64sc_pkg::rsp_type rsp_data
);

   logic [1:0]         idx_ff, idx_in;
   logic               valid_ff, valid_in;
   b64sc_pkg::rsp_type out_ff, out_in;
   logic               load;
   logic               at_end;

   assign load   = !q_empty && (!valid_ff || pop);
   assign at_end = ({1'b0, idx_ff} == head.num - 3'd1);
   assign rd     = load && at_end;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      out_in   = out_ff;
      if (load) begin
         out_in.out_byte    = head.chars[idx_ff];
         out_in.byte_valid  = head.has_data;
         out_in.run_last    = at_end;
         out_in.message_end = at_end && head.last;
         valid_in           = 1'b1;
         idx_in             = at_end ? 2'd0 : idx_ff + 2'd1;
      end else if (pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign empty    = !valid_ff;
   assign rsp_data = out_ff;

`ifndef SYNTH
   a_idx_in_job: assert property (@(posedge clock) disable iff (reset)
      !q_empty |-> ({1'b0, idx_ff} < head.num))
      else $error("Character index ran past the end of the current job.");
   a_end_is_run_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && out_ff.message_end) |-> out_ff.run_last)
      else $error("Message end shown on a response that does not close its request.");
   a_idle_index: assert property (@(posedge clock) disable iff (reset)
      q_empty |-> (idx_ff == 2'd0))
      else $error("Character index left nonzero with no job waiting.");
`endif

endmodule
